### design/buq_pkg.sv
// Shared constants and types for the buffered serial port queues.
// No dependencies; imported by the top level.
package buq_pkg;

    // Default ring depths.
    localparam int TX_DEPTH_DEF = 64;
    localparam int RX_DEPTH_DEF = 64;

    // Bytes used for newline expansion.
    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;

    // Reset value of the newline expansion register.
    localparam logic NL_EXPAND_RST = 1'b1;

    // Request codes.
    typedef enum logic [1:0] {
        ACT_PUT      = 2'd0,
        ACT_TX_READY = 2'd1,
        ACT_RX_BYTE  = 2'd2,
        ACT_GET      = 2'd3
    } t_action;

endpackage

### design/buffered_uart_ring_queues.sv
// Buffered serial port queues: transmit ring and receive ring in one module.
// An accepted request's result is loaded into the output register in the next cycle.
// Throughput: one request per cycle; input stalls only while a held result is stalled.
// Reset (i_rst_n low, synchronous): pointers, full and active flags and the output
// valid clear, newline expansion sets. Ring storage is not cleared.
// Depends on buq_pkg.
module buffered_uart_ring_queues #(
    parameter int TX_DEPTH = buq_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = buq_pkg::RX_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    // Configuration write port (newline expansion).
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,

    // Request channel.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,

    // Result channel.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_line_valid,
    output logic [7:0] o_line_byte,
    output logic       o_read_valid,
    output logic [7:0] o_read_byte,
    output logic       o_tx_full,
    output logic       o_tx_active,
    output logic       o_rx_empty,
    output logic       o_tx_dropped,
    output logic       o_rx_dropped
);

    import buq_pkg::*;

    // Pointers count modulo twice the depth so that full and empty differ.
    // The entry index is the pointer modulo the depth.
    localparam int TPW = $clog2(2 * TX_DEPTH);
    localparam int TSW = $clog2(TX_DEPTH);
    localparam int RPW = $clog2(2 * RX_DEPTH);
    localparam int RSW = $clog2(RX_DEPTH);

    function automatic logic [TSW-1:0] tx_slot(input logic [TPW-1:0] p);
        logic [TPW-1:0] s;
        s = (p >= TPW'(TX_DEPTH)) ? p - TPW'(TX_DEPTH) : p;
        return s[TSW-1:0];
    endfunction

    function automatic logic [TPW-1:0] tx_next(input logic [TPW-1:0] p);
        return (p == TPW'(2 * TX_DEPTH - 1)) ? '0 : p + TPW'(1);
    endfunction

    // Same entry index but different pointers means the ring holds a full depth.
    function automatic logic tx_is_full(input logic [TPW-1:0] t, input logic [TPW-1:0] h);
        return (tx_slot(t) == tx_slot(h)) && (t != h);
    endfunction

    function automatic logic [RSW-1:0] rx_slot(input logic [RPW-1:0] p);
        logic [RPW-1:0] s;
        s = (p >= RPW'(RX_DEPTH)) ? p - RPW'(RX_DEPTH) : p;
        return s[RSW-1:0];
    endfunction

    function automatic logic [RPW-1:0] rx_next(input logic [RPW-1:0] p);
        return (p == RPW'(2 * RX_DEPTH - 1)) ? '0 : p + RPW'(1);
    endfunction

    // ------------------------------------------------------------------
    // State registers.
    // ------------------------------------------------------------------
    logic           r_nl_expand;
    logic [TPW-1:0] r_tx_head, n_tx_head;
    logic [TPW-1:0] r_tx_tail, n_tx_tail;
    logic           r_tx_full, n_tx_full;
    logic           r_tx_active, n_tx_active;
    logic [RPW-1:0] r_rx_head, n_rx_head;
    logic [RPW-1:0] r_rx_tail, n_rx_tail;

    // The transmit ring is split into two banks chosen by pointer parity.
    // An expanded line feed stores two bytes at consecutive pointers, which
    // always land in different banks, so each bank sees one write per cycle.
    logic [7:0] r_tx_mem_even [TX_DEPTH];
    logic [7:0] r_tx_mem_odd  [TX_DEPTH];
    logic [7:0] r_rx_mem      [RX_DEPTH];

    // Prefetched head entries, read at the next head pointer every cycle.
    logic [7:0] r_tx_pre_even, r_tx_pre_odd, r_rx_pre;

    // Output register.
    logic       r_out_valid;
    logic       r_line_valid, n_line_valid;
    logic [7:0] r_line_byte,  n_line_byte;
    logic       r_read_valid, n_read_valid;
    logic [7:0] r_read_byte,  n_read_byte;
    logic       r_tx_dropped, n_tx_dropped;
    logic       r_rx_dropped, n_rx_dropped;
    logic       r_tx_full_o, r_tx_active_o, r_rx_empty_o;

    // ------------------------------------------------------------------
    // Handshake. A request is taken unless a finished result is held.
    // ------------------------------------------------------------------
    logic    accept;
    t_action action;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign action     = t_action'(i_action);

    // ------------------------------------------------------------------
    // Put path. With expansion a carriage return is tried first, then the
    // byte itself; each attempt either goes to the line (transmitter idle),
    // goes into the ring, or is dropped when the ring is full.
    // ------------------------------------------------------------------
    logic           expand;
    logic           cr_drop, cr_line, cr_wr;
    logic           act_after_cr, full_after_cr;
    logic [TPW-1:0] tail_cr, tail_after_cr, tail_d;
    logic           d_drop, d_line, d_wr, full_after_d;
    logic           put_go;

    assign expand        = r_nl_expand && (i_data_byte == LF_BYTE);
    assign cr_drop       = expand & r_tx_full;
    assign cr_line       = expand & ~r_tx_full & ~r_tx_active;
    assign cr_wr         = expand & ~r_tx_full & r_tx_active;
    assign act_after_cr  = r_tx_active | cr_line;
    assign tail_cr       = tx_next(r_tx_tail);
    assign tail_after_cr = cr_wr ? tail_cr : r_tx_tail;
    assign full_after_cr = cr_wr ? tx_is_full(tail_cr, r_tx_head) : r_tx_full;

    assign d_drop        = full_after_cr;
    assign d_line        = ~full_after_cr & ~act_after_cr;
    assign d_wr          = ~full_after_cr & act_after_cr;
    assign tail_d        = tx_next(tail_after_cr);
    assign full_after_d  = d_wr ? tx_is_full(tail_d, r_tx_head) : full_after_cr;

    assign put_go        = accept && (action == ACT_PUT);

    // First ring write lands at the current tail, the second (only when both
    // bytes are stored) at the following pointer.
    logic           wa_en, wb_en;
    logic [7:0]     wa_data;
    logic           tx_we_even, tx_we_odd;
    logic [TSW-1:0] tx_wa_even, tx_wa_odd;
    logic [7:0]     tx_wd_even, tx_wd_odd;

    assign wa_en   = put_go & (cr_wr | d_wr);
    assign wb_en   = put_go & cr_wr & d_wr;
    assign wa_data = cr_wr ? CR_BYTE : i_data_byte;

    always_comb begin
        if (r_tx_tail[0]) begin
            tx_we_odd  = wa_en;
            tx_wa_odd  = tx_slot(r_tx_tail);
            tx_wd_odd  = wa_data;
            tx_we_even = wb_en;
            tx_wa_even = tx_slot(tail_cr);
            tx_wd_even = i_data_byte;
        end else begin
            tx_we_even = wa_en;
            tx_wa_even = tx_slot(r_tx_tail);
            tx_wd_even = wa_data;
            tx_we_odd  = wb_en;
            tx_wa_odd  = tx_slot(tail_cr);
            tx_wd_odd  = i_data_byte;
        end
    end

    // ------------------------------------------------------------------
    // Receive ring status and write.
    // ------------------------------------------------------------------
    logic           rx_full;
    logic           rx_we;
    logic [RSW-1:0] rx_wa;
    logic [7:0]     tx_head_byte;

    assign rx_full      = (rx_slot(r_rx_tail) == rx_slot(r_rx_head)) && (r_rx_tail != r_rx_head);
    assign rx_wa        = rx_slot(r_rx_tail);
    assign tx_head_byte = r_tx_head[0] ? r_tx_pre_odd : r_tx_pre_even;

    // ------------------------------------------------------------------
    // Next state and result for the accepted request.
    // ------------------------------------------------------------------
    always_comb begin
        n_tx_head    = r_tx_head;
        n_tx_tail    = r_tx_tail;
        n_tx_full    = r_tx_full;
        n_tx_active  = r_tx_active;
        n_rx_head    = r_rx_head;
        n_rx_tail    = r_rx_tail;
        rx_we        = 1'b0;
        n_line_valid = 1'b0;
        n_line_byte  = 8'h00;
        n_read_valid = 1'b0;
        n_read_byte  = 8'h00;
        n_tx_dropped = 1'b0;
        n_rx_dropped = 1'b0;
        if (accept) begin
            case (action)
                ACT_PUT: begin
                    n_tx_tail    = d_wr ? tail_d : tail_after_cr;
                    n_tx_full    = full_after_d;
                    n_tx_active  = act_after_cr | d_line;
                    n_line_valid = cr_line | d_line;
                    n_line_byte  = cr_line ? CR_BYTE : (d_line ? i_data_byte : 8'h00);
                    n_tx_dropped = cr_drop | d_drop;
                end
                ACT_TX_READY: begin
                    if (r_tx_head != r_tx_tail) begin
                        n_line_valid = 1'b1;
                        n_line_byte  = tx_head_byte;
                        n_tx_head    = tx_next(r_tx_head);
                        n_tx_full    = 1'b0;
                    end else begin
                        n_tx_active  = 1'b0;
                    end
                end
                ACT_RX_BYTE: begin
                    if (rx_full) begin
                        n_rx_dropped = 1'b1;
                    end else begin
                        rx_we        = 1'b1;
                        n_rx_tail    = rx_next(r_rx_tail);
                    end
                end
                ACT_GET: begin
                    if (r_rx_head != r_rx_tail) begin
                        n_read_valid = 1'b1;
                        n_read_byte  = r_rx_pre;
                        n_rx_head    = rx_next(r_rx_head);
                    end
                end
                default: begin
                    n_tx_head = r_tx_head;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ring storage. Each prefetch register reads the entry that will be at
    // the head next cycle; a write to that same entry is forwarded.
    // ------------------------------------------------------------------
    logic [TSW-1:0] tx_ra;
    logic [RSW-1:0] rx_ra;

    assign tx_ra = tx_slot(n_tx_head);
    assign rx_ra = rx_slot(n_rx_head);

    always_ff @(posedge i_clk) begin
        if (tx_we_even) begin
            r_tx_mem_even[tx_wa_even] <= tx_wd_even;
        end
        r_tx_pre_even <= (tx_we_even && (tx_wa_even == tx_ra)) ? tx_wd_even
                                                                : r_tx_mem_even[tx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tx_we_odd) begin
            r_tx_mem_odd[tx_wa_odd] <= tx_wd_odd;
        end
        r_tx_pre_odd <= (tx_we_odd && (tx_wa_odd == tx_ra)) ? tx_wd_odd
                                                            : r_tx_mem_odd[tx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[rx_wa] <= i_data_byte;
        end
        r_rx_pre <= (rx_we && (rx_wa == rx_ra)) ? i_data_byte : r_rx_mem[rx_ra];
    end

    // ------------------------------------------------------------------
    // Control state and configuration.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nl_expand <= NL_EXPAND_RST;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_full   <= 1'b0;
            r_tx_active <= 1'b0;
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_nl_expand <= i_cfg_wdata;
            end
            r_tx_head   <= n_tx_head;
            r_tx_tail   <= n_tx_tail;
            r_tx_full   <= n_tx_full;
            r_tx_active <= n_tx_active;
            r_rx_head   <= n_rx_head;
            r_rx_tail   <= n_rx_tail;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded only when a request is accepted.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_valid  <= n_line_valid;
            r_line_byte   <= n_line_byte;
            r_read_valid  <= n_read_valid;
            r_read_byte   <= n_read_byte;
            r_tx_full_o   <= n_tx_full;
            r_tx_active_o <= n_tx_active;
            r_rx_empty_o  <= (n_rx_head == n_rx_tail);
            r_tx_dropped  <= n_tx_dropped;
            r_rx_dropped  <= n_rx_dropped;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_valid = r_line_valid;
    assign o_line_byte  = r_line_byte;
    assign o_read_valid = r_read_valid;
    assign o_read_byte  = r_read_byte;
    assign o_tx_full    = r_tx_full_o;
    assign o_tx_active  = r_tx_active_o;
    assign o_rx_empty   = r_rx_empty_o;
    assign o_tx_dropped = r_tx_dropped;
    assign o_rx_dropped = r_rx_dropped;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Bytes enter the transmit ring only while the transmitter is busy, so a
    // full ring implies an active transmitter.
    a_full_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_full |-> r_tx_active)
        else $error("transmit ring full while transmitter idle");

    // The full flag must agree with the pointer distance.
    a_full_matches_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_full == tx_is_full(r_tx_tail, r_tx_head))
        else $error("transmit full flag disagrees with pointers");

    // Every accepted request produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request produced no result");

endmodule
